>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the segment handle table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");
// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");
`endif

>>> src/ssht_pkg.sv
// Types and constants of the shared segment handle table.
package ssht_pkg;
	localparam int SEGMENTS = 32;
	localparam int IDX_W = 5;
	localparam int SEQ_W = 26;
	localparam int CNT_W = 16;
	localparam logic [SEQ_W-1:0] SEQ_MAX = 26'h3ffffff;
	localparam logic [31:0] MAX_BYTES_RESET = 32'd16777216;

	typedef enum logic [2:0] {
		ACT_CREATE = 3'd0, ACT_FIND_KEY = 3'd1, ACT_FIND_ID = 3'd2, ACT_ATTACH = 3'd3,
		ACT_DETACH = 3'd4, ACT_REMOVE = 3'd5, ACT_PERMS = 3'd6, ACT_INFO = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_INVALID = 3'd1, ST_EXISTS = 3'd2, ST_NOTFOUND = 3'd3,
		ST_NOSPACE = 3'd4, ST_OVERFLOW = 3'd5
	} stat_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RD, S_MOD} state_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] size;
		logic [31:0] owner;
		logic [31:0] group;
		logic [8:0] mode;
		logic [SEQ_W-1:0] seq;
		logic [CNT_W-1:0] count;
		logic [31:0] creator;
		logic [31:0] last;
	} entry_t;

	typedef struct packed {
		logic we;
		logic gen_we;
		logic [IDX_W-1:0] addr;
		entry_t ent;
		logic [SEQ_W-1:0] gen;
	} wr_req_t;
endpackage

>>> src/shared_segment_handle_table_unit.sv
// Top level of the shared segment handle table.
//
// Input channel s_*: one item is one table action (tuser = action). Output
// channel m_*: one result item per input item (tuser = status). The table
// handles one item at a time. An item that reads one slot (find id, attach,
// detach, remove, set perms, info) passes through the read and modify
// states to the result. Find key and create with a nonzero key scan the 32
// slots of the entry memory, one slot a cycle through its single read port;
// create with a zero key takes a free slot without a scan. A rejected size
// or key skips the read. The result waits in an output register; a new item
// is accepted while it waits, and the next result is held back until the
// receiver takes it. Reset frees every slot at once through flip-flop flags
// and sets all generations to 1; no clearing pass is needed. The limit
// max_segment_bytes resets to 16777216. The user must write it through
// cfg_we/cfg_wdata while the table is idle; the block does not enforce it.
`include "assert_macros.svh"
module shared_segment_handle_table_unit import ssht_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// key[31:0], ident_in[63:32], slot[68:64], seg_size[100:69], owner[132:101],
	// group[164:133], mode[173:165], pid[212:181], zero fill [215:213] and [180:174]
	input logic [215:0] s_tdata,
	// action[2:0]
	input logic [2:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// slot_out[4:0], ident_out[35:5], key_out[67:36], size_out[99:68],
	// owner_out[131:100], group_out[163:132], mode_out[172:164],
	// attach_count[188:173], creator_pid_out[220:189], last_pid_out[252:221],
	// removed_out[253], zero fill [255:254]
	output logic [255:0] m_tdata,
	// status[2:0]
	output logic [2:0] m_tuser
);
	state_t state_q, state_n;
	logic [31:0] max_bytes_q;
	logic [SEGMENTS-1:0] in_use_q, rem_q, gen_ok_q;
	act_t act_q;
	logic [31:0] key_q, ident_q, size_q, owner_q, group_q, pid_q;
	logic [IDX_W-1:0] slot_q;
	logic [8:0] mode_q;
	logic [IDX_W-1:0] sel_q, sel_n;
	stat_t err_q, err_n;
	logic [IDX_W:0] scan_q;
	logic [255:0] out_data_q;
	logic [2:0] out_stat_q;
	logic out_valid_q;

	entry_t rd_ent;
	logic [SEQ_W-1:0] rd_gen;
	logic [IDX_W-1:0] rd_addr;
	wr_req_t wr;

	logic accept, out_free, go_mod;
	logic [IDX_W-1:0] chk_idx, free_idx;
	logic hit, scan_end, has_free;
	act_t act_in;
	logic [31:0] key_in, ident_in, size_in;
	logic [IDX_W-1:0] slot_in;

	stat_t res_stat;
	entry_t ent_n;
	logic iu_n, rm_n, do_free, upd_flags;
	logic [SEQ_W-1:0] gen_cur, gen_next;
	logic [255:0] res_data;

	assign act_in = act_t'(s_tuser);
	assign key_in = s_tdata[31:0];
	assign ident_in = s_tdata[63:32];
	assign slot_in = s_tdata[68:64];
	assign size_in = s_tdata[100:69];

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign go_mod = (state_q == S_MOD) && out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_stat_q;

	assign chk_idx = IDX_W'(scan_q - (IDX_W+1)'(1));
	assign hit = (scan_q != '0) && in_use_q[chk_idx] && !rem_q[chk_idx]
		&& (rd_ent.key == key_q);
	assign scan_end = hit || (scan_q == (IDX_W+1)'(SEGMENTS));
	assign rd_addr = (state_q == S_SCAN) ? scan_q[IDX_W-1:0] : sel_q;

	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = SEGMENTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = IDX_W'(i);
				has_free = 1'b1;
			end
		end
	end

	// Next state, selected slot and early error code.
	always_comb begin
		state_n = state_q;
		sel_n = sel_q;
		err_n = err_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					err_n = ST_OK;
					state_n = S_RD;
					sel_n = slot_in;
					case (act_in)
						ACT_CREATE: begin
							if (size_in == '0 || size_in > max_bytes_q) begin
								err_n = ST_INVALID;
								state_n = S_MOD;
							end else if (key_in != '0) begin
								state_n = S_SCAN;
							end else if (!has_free) begin
								err_n = ST_NOSPACE;
								state_n = S_MOD;
							end else begin
								sel_n = free_idx;
							end
						end
						ACT_FIND_KEY: begin
							if (key_in == '0) begin
								err_n = ST_INVALID;
								state_n = S_MOD;
							end else begin
								state_n = S_SCAN;
							end
						end
						ACT_FIND_ID: begin
							sel_n = ident_in[IDX_W-1:0];
							if (ident_in[31] || ident_in[31:IDX_W] == '0
								|| {1'b0, ident_in[IDX_W-1:0]} >= (IDX_W+1)'(SEGMENTS)) begin
								err_n = ST_INVALID;
								state_n = S_MOD;
							end
						end
						default: begin
							if ({1'b0, slot_in} >= (IDX_W+1)'(SEGMENTS)) begin
								err_n = ST_INVALID;
								state_n = S_MOD;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					if (act_q == ACT_CREATE) begin
						if (hit) begin
							err_n = ST_EXISTS;
							state_n = S_MOD;
						end else if (!has_free) begin
							err_n = ST_NOSPACE;
							state_n = S_MOD;
						end else begin
							sel_n = free_idx;
							state_n = S_RD;
						end
					end else if (hit) begin
						sel_n = chk_idx;
						state_n = S_RD;
					end else begin
						err_n = ST_NOTFOUND;
						state_n = S_MOD;
					end
				end
			end
			S_RD: state_n = S_MOD;
			S_MOD: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Read-modify-write of the selected slot and the result it gives.
	always_comb begin
		logic iu, rm;
		iu = in_use_q[sel_q];
		rm = rem_q[sel_q];
		gen_cur = gen_ok_q[sel_q] ? rd_gen : SEQ_W'(1);
		gen_next = (gen_cur >= SEQ_MAX) ? SEQ_W'(1) : gen_cur + SEQ_W'(1);
		ent_n = rd_ent;
		iu_n = iu;
		rm_n = rm;
		do_free = 1'b0;
		upd_flags = 1'b0;
		res_stat = err_q;
		if (err_q == ST_OK) begin
			case (act_q)
				ACT_CREATE: begin
					ent_n.key = key_q;
					ent_n.size = size_q;
					ent_n.owner = owner_q;
					ent_n.group = group_q;
					ent_n.mode = mode_q;
					ent_n.seq = gen_cur;
					ent_n.count = '0;
					ent_n.creator = pid_q;
					ent_n.last = '0;
					iu_n = 1'b1;
					rm_n = 1'b0;
					upd_flags = 1'b1;
				end
				ACT_FIND_KEY: ;
				ACT_FIND_ID: begin
					if (!iu || rm || rd_ent.seq != ident_q[IDX_W+SEQ_W-1:IDX_W]) begin
						res_stat = ST_INVALID;
					end
				end
				default: begin
					if (!iu) begin
						res_stat = ST_INVALID;
					end else begin
						case (act_q)
							ACT_ATTACH: begin
								if (rm && pid_q != '0) begin
									res_stat = ST_INVALID;
								end else if (rd_ent.count == '1) begin
									res_stat = ST_OVERFLOW;
								end else begin
									ent_n.count = rd_ent.count + CNT_W'(1);
									if (pid_q != '0) begin
										ent_n.last = pid_q;
									end
								end
							end
							ACT_DETACH: begin
								if (rd_ent.count == '0) begin
									res_stat = ST_INVALID;
								end else begin
									ent_n.count = rd_ent.count - CNT_W'(1);
									if (pid_q != '0) begin
										ent_n.last = pid_q;
									end
									do_free = rm && (ent_n.count == '0);
								end
							end
							ACT_REMOVE: begin
								if (rm) begin
									res_stat = ST_INVALID;
								end else begin
									rm_n = 1'b1;
									upd_flags = 1'b1;
									ent_n.key = '0;
									ent_n.last = pid_q;
									do_free = (rd_ent.count == '0);
								end
							end
							ACT_PERMS: begin
								if (rm) begin
									res_stat = ST_INVALID;
								end else begin
									ent_n.owner = owner_q;
									ent_n.group = group_q;
									ent_n.mode = mode_q;
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
		if (do_free) begin
			iu_n = 1'b0;
			rm_n = 1'b0;
			upd_flags = 1'b1;
		end
		res_data = '0;
		if (res_stat == ST_OK) begin
			res_data[4:0] = sel_q;
			if (do_free) begin
				res_data[35:5] = {{SEQ_W{1'b0}}, sel_q};
			end else begin
				res_data[35:5] = {ent_n.seq, sel_q};
				res_data[67:36] = ent_n.key;
				res_data[99:68] = ent_n.size;
				res_data[131:100] = ent_n.owner;
				res_data[163:132] = ent_n.group;
				res_data[172:164] = ent_n.mode;
				res_data[188:173] = ent_n.count;
				res_data[220:189] = ent_n.creator;
				res_data[252:221] = ent_n.last;
				res_data[253] = rm_n;
			end
		end
		wr.we = go_mod && (res_stat == ST_OK);
		wr.gen_we = go_mod && (res_stat == ST_OK) && do_free;
		wr.addr = sel_q;
		wr.ent = ent_n;
		wr.gen = gen_next;
	end

	ssht_store u_store (
		.clk(clk),
		.rd_addr(rd_addr),
		.rd_ent(rd_ent),
		.rd_gen(rd_gen),
		.wr(wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_bytes_q <= MAX_BYTES_RESET;
			in_use_q <= '0;
			rem_q <= '0;
			gen_ok_q <= '0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
			sel_q <= '0;
			err_q <= ST_OK;
		end else begin
			state_q <= state_n;
			sel_q <= sel_n;
			err_q <= err_n;
			if (cfg_we) begin
				max_bytes_q <= cfg_wdata;
			end
			if (state_q == S_SCAN) begin
				scan_q <= scan_q + (IDX_W+1)'(1);
			end else begin
				scan_q <= '0;
			end
			if (go_mod && (res_stat == ST_OK) && upd_flags) begin
				in_use_q[sel_q] <= iu_n;
				rem_q[sel_q] <= rm_n;
			end
			if (wr.gen_we) begin
				gen_ok_q[sel_q] <= 1'b1;
			end
			if (go_mod) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= act_in;
			key_q <= key_in;
			ident_q <= ident_in;
			slot_q <= slot_in;
			size_q <= size_in;
			owner_q <= s_tdata[132:101];
			group_q <= s_tdata[164:133];
			mode_q <= s_tdata[173:165];
			pid_q <= s_tdata[212:181];
		end
		if (go_mod) begin
			out_data_q <= res_data;
			out_stat_q <= res_stat;
		end
	end

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	`ASSERT_NEXT(a_mod_result, clk, arst_n, go_mod, m_tvalid)
	`ASSERT_NEXT(a_flags_only_in_mod, clk, arst_n, state_q != S_MOD,
		$stable(in_use_q) && $stable(rem_q))
	`ASSERT_IMPL(a_slot_known, clk, arst_n, state_q == S_RD && act_q > ACT_FIND_ID,
		sel_q == slot_q)
endmodule

>>> src/ssht_store.sv
// Slot entry memory and generation memory, with registered reads.
module ssht_store import ssht_pkg::*; (
	input logic clk,
	input logic [IDX_W-1:0] rd_addr,
	output entry_t rd_ent,
	output logic [SEQ_W-1:0] rd_gen,
	input wr_req_t wr
);
	entry_t ent_mem [SEGMENTS];
	logic [SEQ_W-1:0] gen_mem [SEGMENTS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			ent_mem[wr.addr] <= wr.ent;
		end
		if (wr.gen_we) begin
			gen_mem[wr.addr] <= wr.gen;
		end
		rd_ent <= ent_mem[rd_addr];
		rd_gen <= gen_mem[rd_addr];
	end
endmodule
